[rtl/core/ritt_pkg.sv]
`default_nettype none

package ritt_pkg;

	// Field and register widths and the digit stack depth that the item format fixes.
	localparam int RADIX_W     = 7;
	localparam int NUMBER_W    = 32;
	localparam int STACK_DEPTH = 32;
	localparam int DEPTH_W     = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
	localparam logic [RADIX_W-1:0] MIN_RADIX   = 7'd2;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_CONVERT = 1'b1
	} command_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic chk_run;
		logic div_step;
		logic pop;
		logic sym_rd;
		logic emit_err;
		logic emit_sign;
		logic emit_digit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic radix_ok;
		logic chk_done;
		logic chk_bad;
		logic div_done;
		logic neg;
		logic depth_zero;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/ritt_stream_if.sv]
`default_nettype none

interface ritt_item_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [5:0]         symbol_index;
	logic [7:0]         symbol_char;
	logic signed [31:0] number;

	modport source (output valid, command, symbol_index, symbol_char, number, input ready);
	modport sink (input valid, command, symbol_index, symbol_char, number, output ready);
endinterface

interface ritt_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       status;
	logic       last;

	modport source (output valid, out_char, status, last, input ready);
	modport sink (input valid, out_char, status, last, output ready);
endinterface

`default_nettype wire

[rtl/core/radix_integer_to_text_unit.sv]
`default_nettype none

// Converts a signed 32-bit number into text in a programmable base, using an
// alphabet of digit symbols that load items write one entry at a time. A load
// item gives no result and leaves input ready. A convert item first checks the
// base: the radix register must lie between 2 and MAX_SYMBOLS, and the first
// radix alphabet entries must all differ and contain neither '+' nor '-';
// otherwise a single result with status 1, character 0 and last 1 comes out.
// For a good base the block sends '-' for a negative number and then the
// digits most significant first, with last set on the final character.
// Every alphabet entry in use must have been written since reset. A convert
// item runs the alphabet check, which reads the alphabet memory one entry per
// cycle, then the divider, which retires eight quotient bits per cycle, then
// sends each character through the digit stack and alphabet read ports.
// Base 2 on the most negative number is the longest case. Input items are
// taken only while no conversion is running; a finished character waits in
// the output register, so the next item can be taken while the last
// transfer of the previous one is still pending. The radix register must be
// written only while the block is idle.

module radix_integer_to_text_unit import ritt_pkg::*; #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [RADIX_W-1:0] wr_data,
	ritt_item_if.sink          item,
	ritt_result_if.source      result
);

	logic [RADIX_W-1:0] radix_q;
	ctrl_cmd_t          cmd;
	dp_stat_t           stat;
	logic               in_ready;

	// The radix register is also the number of alphabet symbols in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (wr_en) begin
			radix_q <= wr_data;
		end
	end

	assign item.ready = in_ready;

	// The controller sequences check, division and character output; it only
	// sees the status flags of the datapath.
	ritt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_command (item.command),
		.in_ready   (in_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath holds the alphabet, the divider, the digit stack and the
	// output register that feeds each result transfer.
	ritt_datapath #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix        (radix_q),
		.symbol_index (item.symbol_index),
		.symbol_char  (item.symbol_char),
		.number       (item.number),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result)
	);

endmodule

`default_nettype wire

[rtl/core/ritt_ctrl.sv]
`default_nettype none

module ritt_ctrl import ritt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_command,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_SIGN  = 8'b0000_1000,
		ST_POP   = 8'b0001_0000,
		ST_SYM   = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_ERR   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == CMD_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start  = 1'b1;
						state_next = stat.radix_ok ? ST_CHECK : ST_ERR;
					end
				end
			end
			ST_CHECK: begin
				cmd.chk_run = 1'b1;
				if (stat.chk_done) begin
					state_next = stat.chk_bad ? ST_ERR : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_next = stat.neg ? ST_SIGN : ST_POP;
				end
			end
			ST_SIGN: begin
				if (stat.out_free) begin
					cmd.emit_sign = 1'b1;
					state_next    = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop    = 1'b1;
				state_next = ST_SYM;
			end
			ST_SYM: begin
				cmd.sym_rd = 1'b1;
				state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					state_next     = stat.depth_zero ? ST_IDLE : ST_POP;
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

[rtl/core/ritt_datapath.sv]
`default_nettype none

module ritt_datapath import ritt_pkg::*; #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [RADIX_W-1:0]  radix,
	input  logic [5:0]          symbol_index,
	input  logic [7:0]          symbol_char,
	input  logic signed [31:0]  number,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	ritt_result_if.source       result
);

	localparam int AW  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int SAW = $clog2(STACK_DEPTH);

	// Alphabet memory, one write port and one registered read port.
	logic [7:0]    alpha_mem [MAX_SYMBOLS];
	logic [7:0]    alpha_rd_q;
	logic [AW-1:0] alpha_raddr;
	logic          alpha_we;

	// Digit stack memory.
	logic [AW-1:0]  stack_mem [STACK_DEPTH];
	logic [AW-1:0]  stack_rd_q;
	logic [SAW-1:0] pop_addr;

	logic [NUMBER_W-1:0] mag_q;
	logic [NUMBER_W-1:0] mag_next;
	logic [RADIX_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  rem_in;
	logic [RADIX_W-1:0]  div_rem;
	logic [RADIX_W:0]    div_trial;
	logic [7:0]          qbits;
	logic [1:0]          div_cnt_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                neg_q;
	logic                push;

	logic [RADIX_W-1:0] chk_idx_q;
	logic               chk_v_s1;
	logic               chk_bad_q;
	logic [255:0]       seen_q;
	logic               chk_hit;

	logic [7:0] out_char_q;
	logic       status_q;
	logic       last_q;
	logic       out_valid_q;
	logic       out_free;

	assign alpha_we    = cmd.load && (32'(symbol_index) < MAX_SYMBOLS);
	assign alpha_raddr = cmd.sym_rd ? stack_rd_q : AW'(chk_idx_q);

	always_ff @(posedge clk) begin
		if (alpha_we) begin
			alpha_mem[AW'(symbol_index)] <= symbol_char;
		end
		if (cmd.chk_run || cmd.sym_rd) begin
			alpha_rd_q <= alpha_mem[alpha_raddr];
		end
	end

	// Eight restoring steps per cycle; the dividend shifts out of the top of
	// mag_q while the quotient bits shift in at the bottom.
	always_comb begin
		rem_in  = (div_cnt_q == 2'd0) ? '0 : rem_q;
		div_rem = rem_in;
		qbits   = '0;
		for (int k = 7; k >= 0; k--) begin
			div_trial = {div_rem, mag_q[NUMBER_W-8+k]};
			if (div_trial >= {1'b0, radix}) begin
				div_rem  = RADIX_W'(div_trial - {1'b0, radix});
				qbits[k] = 1'b1;
			end else begin
				div_rem  = div_trial[RADIX_W-1:0];
			end
		end
		mag_next = {mag_q[NUMBER_W-9:0], qbits};
	end

	assign push     = cmd.div_step && (div_cnt_q == 2'd3);
	assign pop_addr = SAW'(depth_q - DEPTH_W'(1));

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[depth_q[SAW-1:0]] <= AW'(div_rem);
		end
		if (cmd.pop) begin
			stack_rd_q <= stack_mem[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= number[NUMBER_W-1];
			mag_q <= number[NUMBER_W-1] ? (NUMBER_W'(0) - unsigned'(number))
			                            : unsigned'(number);
		end else if (cmd.div_step) begin
			mag_q <= mag_next;
			rem_q <= div_rem;
		end
	end

	assign chk_hit = (alpha_rd_q == CHAR_PLUS) || (alpha_rd_q == CHAR_MINUS) ||
	                 seen_q[alpha_rd_q];

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			seen_q <= '0;
		end else if (cmd.chk_run && chk_v_s1) begin
			seen_q[alpha_rd_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			depth_q   <= '0;
			chk_idx_q <= '0;
			chk_v_s1  <= 1'b0;
			chk_bad_q <= 1'b0;
		end else if (cmd.start) begin
			div_cnt_q <= '0;
			depth_q   <= '0;
			chk_idx_q <= '0;
			chk_v_s1  <= 1'b0;
			chk_bad_q <= 1'b0;
		end else begin
			if (cmd.chk_run) begin
				if (chk_idx_q != radix) begin
					chk_idx_q <= chk_idx_q + RADIX_W'(1);
					chk_v_s1  <= 1'b1;
				end else begin
					chk_v_s1  <= 1'b0;
				end
				if (chk_v_s1 && chk_hit) begin
					chk_bad_q <= 1'b1;
				end
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 2'd1;
			end
			if (push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
		end
	end

	// Output register.
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_char_q <= 8'd0;
			status_q   <= 1'b1;
			last_q     <= 1'b1;
		end else if (cmd.emit_sign) begin
			out_char_q <= CHAR_MINUS;
			status_q   <= 1'b0;
			last_q     <= 1'b0;
		end else if (cmd.emit_digit) begin
			out_char_q <= alpha_rd_q;
			status_q   <= 1'b0;
			last_q     <= (depth_q == '0);
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_char = out_char_q;
	assign result.status   = status_q;
	assign result.last     = last_q;

	always_comb begin
		stat.radix_ok   = (radix >= MIN_RADIX) && (32'(radix) <= MAX_SYMBOLS);
		stat.chk_done   = (chk_idx_q == radix) && !chk_v_s1;
		stat.chk_bad    = chk_bad_q;
		stat.div_done   = (div_cnt_q == 2'd3) &&
		                  ((mag_next == '0) || (depth_q == DEPTH_W'(STACK_DEPTH - 1)));
		stat.neg        = neg_q;
		stat.depth_zero = (depth_q == '0);
		stat.out_free   = out_free;
	end

endmodule

`default_nettype wire

[rtl/core/ritt_checker.sv]
`default_nettype none

module ritt_checker import ritt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_command,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_char,
	input logic       result_status,
	input logic       result_last
);

	// An error result stands alone and carries no character.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_status |-> result_last && (result_char == 8'd0))
		else $error("error result without last or with a character");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid &&
		$stable(result_char) && $stable(result_status) && $stable(result_last))
		else $error("stalled result changed");

	// A convert transfer starts a conversion that blocks further items.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == CMD_CONVERT) |=> !item_ready)
		else $error("input still ready after a convert transfer");

	// A load transfer finishes at once and leaves the block ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == CMD_LOAD) |=> item_ready)
		else $error("input not ready after a load transfer");

endmodule

bind radix_integer_to_text_unit ritt_checker u_ritt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_command  (item.command),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_char   (result.out_char),
	.result_status (result.status),
	.result_last   (result.last)
);

`default_nettype wire

[tb/sv/tb_radix_integer_to_text_unit.sv]
`timescale 1ns / 100ps

// Self-checking bench for the radix text converter.
//
// The bench fills the digit alphabet and then walks a short table of directed
// items. Some rows carry the text or error that the block must produce. The
// other rows are checked against an in-bench model of the converter. After the
// table come random phases. Each phase starts from an idle block, writes a new
// radix and repairs the alphabet so that most conversions see a usable base. It
// then sends a mix of alphabet loads and conversions, with a small share of
// loads that break the alphabet on purpose. Both handshake sides idle in random
// bursts. One phase holds the result side off for a long stretch, so the block
// backs up into its input, and the last phase runs with no idling at all.

module tb_radix_integer_to_text_unit;
	import ritt_pkg::*;

	localparam int SYMBOLS       = 64;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 40;
	localparam int LONG_HOLD     = 400;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 20;
	localparam int HOLD_PHASE    = 2;

	// Radix picks for the random phases that are not a fixed value.
	localparam int PICK_VALID = -1;
	localparam int PICK_BAD   = -2;

	// Where the expected text of an item comes from.
	typedef enum logic [1:0] {
		GOLD_MODEL,
		GOLD_TEXT,
		GOLD_ERROR
	} golden_kind_t;

	typedef struct {
		golden_kind_t kind;
		string        text;
	} golden_t;

	// One result transfer as the block sends it.
	typedef struct packed {
		logic [7:0] out_char;
		logic       status;
		logic       last;
	} text_char_t;

	// One row of the directed table. The radix is written before the row
	// whenever it differs from the one in force.
	typedef struct {
		int                 radix;
		command_t           command;
		logic [5:0]         symbol_index;
		logic [7:0]         symbol_char;
		logic signed [31:0] number;
		golden_kind_t       kind;
		string              text;
	} row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [RADIX_W-1:0] wr_data;

	ritt_item_if   item_ch ();
	ritt_result_if result_ch ();

	radix_integer_to_text_unit #(
		.MAX_SYMBOLS(SYMBOLS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_data(wr_data),
		.item   (item_ch),
		.result (result_ch)
	);

	// The starting alphabet has 64 distinct symbols and neither sign character.
	// Position 63 is '_', so 4095 in base 64 reads "__".
	string start_alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz@_";

	// The directed table. The first rows run at the radix that reset leaves.
	// The row texts assume the starting alphabet above.
	row_t plan [25] = '{
		'{10,  CMD_CONVERT, 6'd0,  8'h00, 32'sd0,          GOLD_TEXT,  "0"},
		'{10,  CMD_CONVERT, 6'd63, 8'hFF, 32'sd10,         GOLD_TEXT,  "10"},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, -32'sd1,         GOLD_TEXT,  "-1"},
		'{10,  CMD_CONVERT, 6'd21, 8'h5A, 32'sh7FFF_FFFF,  GOLD_TEXT,  "2147483647"},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, 32'sh8000_0000,  GOLD_TEXT,  "-2147483648"},
		'{2,   CMD_CONVERT, 6'd0,  8'h00, 32'sh8000_0000,  GOLD_MODEL, ""},
		'{2,   CMD_CONVERT, 6'd0,  8'h00, 32'sd5,          GOLD_TEXT,  "101"},
		'{64,  CMD_CONVERT, 6'd0,  8'h00, 32'sd4095,       GOLD_TEXT,  "__"},
		'{64,  CMD_CONVERT, 6'd0,  8'h00, 32'sh8000_0000,  GOLD_MODEL, ""},
		'{0,   CMD_CONVERT, 6'd0,  8'h00, 32'sd1,          GOLD_ERROR, ""},
		'{1,   CMD_CONVERT, 6'd0,  8'h00, 32'sd1,          GOLD_ERROR, ""},
		'{65,  CMD_CONVERT, 6'd0,  8'h00, 32'sd1,          GOLD_ERROR, ""},
		'{127, CMD_CONVERT, 6'd0,  8'h00, 32'sd1,          GOLD_ERROR, ""},
		'{10,  CMD_LOAD,    6'd3,  8'h2B, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, 32'sd3,          GOLD_ERROR, ""},
		'{10,  CMD_LOAD,    6'd3,  8'h2D, -32'sd1,         GOLD_MODEL, ""},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, 32'sd3,          GOLD_ERROR, ""},
		'{10,  CMD_LOAD,    6'd3,  8'h39, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, 32'sd3,          GOLD_ERROR, ""},
		'{10,  CMD_LOAD,    6'd3,  8'h33, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_LOAD,    6'd10, 8'h2B, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_LOAD,    6'd0,  8'h00, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_CONVERT, 6'd0,  8'h00, -32'sd100,       GOLD_MODEL, ""},
		'{10,  CMD_LOAD,    6'd0,  8'h30, 32'sd0,          GOLD_MODEL, ""},
		'{10,  CMD_LOAD,    6'd10, 8'h41, 32'sd0,          GOLD_MODEL, ""}
	};

	int phase_radix [PHASES] = '{64, 2, PICK_VALID, PICK_BAD, 36, PICK_VALID, 3, PICK_VALID};
	int phase_idle [PHASES]  = '{25, 10, 30, 0, 20, 40, 15, 0};

	// Model state, updated only from what the block actually accepted.
	logic [7:0]         model_alphabet [SYMBOLS];
	logic [RADIX_W-1:0] model_radix;

	// Stimulus-side copy of the alphabet and radix, used to shape the items.
	logic [7:0] stim_alphabet [SYMBOLS];
	int         stim_radix;

	golden_t    pending_golden_q [$];
	text_char_t expected_text_q [$];

	int idle_pct;
	bit hold_request;
	int mismatches;
	int items_sent;
	int conversions;
	int chars_checked;
	int bad_base_results;
	int radix_settings;
	int long_holds;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A base is usable when the radix lies between 2 and the alphabet size, and
	// the symbols in use are all distinct and contain neither sign character.
	function automatic bit base_usable();
		if (model_radix < MIN_RADIX || model_radix > SYMBOLS)
			return 1'b0;
		for (int i = 0; i < model_radix; i++) begin
			if (model_alphabet[i] == CHAR_PLUS || model_alphabet[i] == CHAR_MINUS)
				return 1'b0;
			for (int j = i + 1; j < model_radix; j++) begin
				if (model_alphabet[i] == model_alphabet[j])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Works out the text that one accepted item must produce and queues it.
	// A load only updates the alphabet. A conversion with a typed result uses
	// that result. Others are rendered here, as digits or as the error result.
	task automatic render_expected_text(golden_t gold, logic cmd, logic [5:0] idx,
			logic [7:0] ch, logic [31:0] num);
		logic [5:0]  digits [STACK_DEPTH];
		logic [31:0] magnitude;
		int          depth;
		string       s;

		if (cmd == CMD_LOAD) begin
			model_alphabet[idx] = ch;
			return;
		end
		conversions++;
		case (gold.kind)
			GOLD_ERROR: begin
				expected_text_q.push_back('{8'h00, 1'b1, 1'b1});
			end
			GOLD_TEXT: begin
				s = gold.text;
				for (int i = 0; i < s.len(); i++)
					expected_text_q.push_back('{s[i], 1'b0, i == s.len() - 1});
			end
			default: begin
				if (!base_usable()) begin
					expected_text_q.push_back('{8'h00, 1'b1, 1'b1});
				end else begin
					// The magnitude of the most negative number still fits in
					// 32 unsigned bits, so the two's complement negation is exact.
					magnitude = num[31] ? 32'd0 - num : num;
					depth = 0;
					do begin
						digits[depth] = 6'(magnitude % model_radix);
						magnitude = magnitude / model_radix;
						depth++;
					end while (magnitude != 0 && depth < STACK_DEPTH);
					if (num[31])
						expected_text_q.push_back('{CHAR_MINUS, 1'b0, 1'b0});
					while (depth > 0) begin
						depth--;
						expected_text_q.push_back('{model_alphabet[digits[depth]], 1'b0,
							depth == 0});
					end
				end
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, text_char_t want, text_char_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected char %02h status %0b last %0b, got char %02h status %0b last %0b",
				$time, what, want.out_char, want.status, want.last,
				got.out_char, got.status, got.last);
	endtask

	// Monitor. Everything is sampled at the rising edge, where the bench's own
	// drives still hold their values from before the edge. A result transfer is
	// checked before the input transfer of the same edge is modeled, so a
	// result can never be matched against text of an item that it cannot
	// belong to yet.
	always @(posedge clk) begin : monitor
		text_char_t got;
		text_char_t want;
		golden_t    gold;

		if (arst_n) begin
			if (wr_en)
				model_radix = wr_data;
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.out_char, result_ch.status, result_ch.last};
				chars_checked++;
				if (got.status)
					bad_base_results++;
				if (expected_text_q.size() == 0) begin
					flag_mismatch("character with nothing expected", '0, got);
				end else begin
					want = expected_text_q.pop_front();
					if (got.out_char !== want.out_char || got.status !== want.status
							|| got.last !== want.last)
						flag_mismatch("character differs", want, got);
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				gold = '{GOLD_MODEL, ""};
				if (pending_golden_q.size() != 0)
					gold = pending_golden_q.pop_front();
				render_expected_text(gold, item_ch.command, item_ch.symbol_index,
					item_ch.symbol_char, item_ch.number);
			end
		end
	end

	// Result side. It stalls in random bursts, and when asked for a long hold
	// it keeps ready low through a LONG_HOLD countdown while the sender carries on.
	initial begin : result_side
		int stall_left;

		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
				long_holds++;
			end else if (stall_left == 0 && $urandom_range(0, 199) < idle_pct) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one item and returns at the edge where it transfers. Valid is
	// left high, so back-to-back items keep it high without a dip.
	task automatic send_item(command_t cmd, logic [5:0] idx, logic [7:0] ch,
			logic signed [31:0] num, golden_kind_t kind, string text);
		int      gap;
		golden_t gold;

		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 11) : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		gold.kind = kind;
		gold.text = text;
		pending_golden_q.push_back(gold);
		if (cmd == CMD_LOAD)
			stim_alphabet[idx] = ch;
		items_sent++;
		item_ch.command      <= cmd;
		item_ch.symbol_index <= idx;
		item_ch.symbol_char  <= ch;
		item_ch.number       <= num;
		item_ch.valid        <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// Stops offering and waits until every accepted item has produced all of
	// its text. A load gives no result, so a settling wait follows after that.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_golden_q.size() != 0 || expected_text_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(int value);
		settle();
		wr_en   <= 1'b1;
		wr_data <= 7'(value);
		@(posedge clk);
		wr_en <= 1'b0;
		stim_radix = value;
		radix_settings++;
	endtask

	// A symbol that is not in the alphabet anywhere and is not a sign, so a
	// load of it keeps a usable base usable.
	function automatic logic [7:0] fresh_symbol();
		logic [7:0] c;
		bit         taken;

		do begin
			c = 8'($urandom_range(0, 255));
			taken = (c == CHAR_PLUS || c == CHAR_MINUS);
			for (int i = 0; i < SYMBOLS; i++) begin
				if (stim_alphabet[i] == c)
					taken = 1'b1;
			end
		end while (taken);
		return c;
	endfunction

	// Rewrites the symbols in use that would make the base unusable, so that a
	// phase does not spend all of its conversions on the error result.
	task automatic repair_alphabet();
		bit clash;

		for (int i = 0; i < stim_radix && i < SYMBOLS; i++) begin
			clash = (stim_alphabet[i] == CHAR_PLUS || stim_alphabet[i] == CHAR_MINUS);
			for (int j = 0; j < i; j++) begin
				if (stim_alphabet[j] == stim_alphabet[i])
					clash = 1'b1;
			end
			if (clash)
				send_item(CMD_LOAD, 6'(i), fresh_symbol(), $urandom, GOLD_MODEL, "");
		end
	endtask

	// One random item: mostly conversions, some clean loads of fresh symbols,
	// and a few loads that may duplicate a symbol or plant a sign.
	task automatic random_item();
		logic [5:0]         idx;
		logic [7:0]         ch;
		logic signed [31:0] num;
		int                 pick;

		idx = 6'($urandom_range(0, 63));
		ch = 8'($urandom_range(0, 255));
		num = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			send_item(CMD_LOAD, idx, fresh_symbol(), num, GOLD_MODEL, "");
		end else if (pick < 27) begin
			if ($urandom_range(0, 1))
				ch = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
			send_item(CMD_LOAD, idx, ch, num, GOLD_MODEL, "");
		end else begin
			case ($urandom_range(0, 4))
				0: ;
				1: num = $urandom_range(0, 5000);
				2: num = 32'sd0 - 32'($urandom_range(1, 5000));
				3: begin
					case ($urandom_range(0, 3))
						0: num = 32'sh8000_0000;
						1: num = 32'sh7FFF_FFFF;
						2: num = -32'sd1;
						default: num = stim_radix - 1;
					endcase
				end
				default: num = stim_radix * $urandom_range(0, stim_radix);
			endcase
			send_item(CMD_CONVERT, idx, ch, num, GOLD_MODEL, "");
		end
	endtask

	initial begin : stimulus
		int next_radix;

		arst_n               <= 1'b0;
		wr_en                <= 1'b0;
		wr_data              <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.command      <= CMD_LOAD;
		item_ch.symbol_index <= '0;
		item_ch.symbol_char  <= '0;
		item_ch.number       <= '0;
		model_radix = RADIX_RESET;
		stim_radix = RADIX_RESET;
		idle_pct = 20;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every alphabet position is written before the first conversion, so
		// the base check never reads an entry that holds no symbol yet.
		for (int i = 0; i < SYMBOLS; i++)
			send_item(CMD_LOAD, 6'(i), start_alphabet[i], $urandom, GOLD_MODEL, "");

		// Directed part. Radix changes happen only with the block drained.
		foreach (plan[r]) begin
			if (plan[r].radix != stim_radix)
				write_radix(plan[r].radix);
			send_item(plan[r].command, plan[r].symbol_index, plan[r].symbol_char,
				plan[r].number, plan[r].kind, plan[r].text);
		end

		// Random phases. Each one begins with the sender paused until every
		// expected character has come back, then writes the new radix.
		for (int p = 0; p < PHASES; p++) begin
			case (phase_radix[p])
				PICK_VALID: next_radix = $urandom_range(2, SYMBOLS);
				PICK_BAD: next_radix = $urandom_range(0, 1) ? $urandom_range(0, 1)
					: $urandom_range(SYMBOLS + 1, 127);
				default: next_radix = phase_radix[p];
			endcase
			idle_pct = phase_idle[p];
			write_radix(next_radix);
			repair_alphabet();
			// The long hold backs the block up into its input while the
			// sender keeps offering items.
			if (p == HOLD_PHASE)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb_radix_integer_to_text_unit: %0d items, %0d conversions, %0d radix writes",
			items_sent, conversions, radix_settings);
		$display("tb_radix_integer_to_text_unit: %0d characters checked, %0d bad-base results, %0d long holds, %0d mismatches",
			chars_checked, bad_base_results, long_holds, mismatches);
		if (mismatches == 0) begin
			$display("tb_radix_integer_to_text_unit: done, clean");
		end else begin
			$display("tb_radix_integer_to_text_unit: done, errors");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run: every conversion in base 2
	// with the result side stalling on each character.
	initial begin : watchdog
		int cycles;

		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_radix_integer_to_text_unit: timeout after %0d cycles", cycles);
		$display("tb_radix_integer_to_text_unit: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ritt_pkg.sv
rtl/core/ritt_stream_if.sv
rtl/core/ritt_ctrl.sv
rtl/core/ritt_datapath.sv
rtl/core/radix_integer_to_text_unit.sv
rtl/core/ritt_checker.sv
tb/sv/tb_radix_integer_to_text_unit.sv
